FILE: rtl/cqse_pkg.sv
// Shared types and codes for the circular queue search/edit core.
`default_nettype none

package cqse_pkg;

    // Default queue depth
    localparam int DEPTH_DEF = 8;

    // Command codes
    localparam logic [2:0] CMD_ENQ  = 3'd0;
    localparam logic [2:0] CMD_DEQ  = 3'd1;
    localparam logic [2:0] CMD_TRAV = 3'd2;
    localparam logic [2:0] CMD_SRCH = 3'd3;
    localparam logic [2:0] CMD_EDIT = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_MISS  = 2'd3;

    // One decoded command as it waits between front and back
    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] data;
        logic signed [31:0] repl;
    } cqse_cmd_t;

    // Command request from front to back
    typedef struct packed {
        logic      valid;
        cqse_cmd_t cmd;
    } cqse_req_t;

endpackage

`default_nettype wire

FILE: rtl/cqse_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cqse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read; hold data while no read is issued
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/cqse_front.sv
// Front end: accepts input transfers, drops unused codes, queues commands.
`default_nettype none

module cqse_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_command,
    input  wire logic signed [31:0] s_data_value,
    input  wire logic signed [31:0] s_replacement,
    output cqse_pkg::cqse_req_t     req,
    input  wire logic               req_ready
);
    import cqse_pkg::*;

    cqse_cmd_t   slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        known;
    logic        push;
    logic        pop;
    cqse_cmd_t   incoming;

    // Classify the command; unused codes cause nothing
    assign known = s_command inside {CMD_ENQ, CMD_DEQ, CMD_TRAV, CMD_SRCH, CMD_EDIT};

    assign s_ready   = (cnt_reg != 2'd2);
    assign push      = s_valid && s_ready && known;
    assign pop       = req.valid && req_ready;
    assign req.valid = (cnt_reg != 2'd0);
    assign req.cmd   = slot_reg[rd_ptr_reg];

    assign incoming.op   = s_command;
    assign incoming.data = s_data_value;
    assign incoming.repl = s_replacement;

    // Advance queue pointers and count
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the queued command
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/cqse_back.sv
// Back end: executes queued commands against the ring buffer and drives results.
`default_nettype none

module cqse_back #(
    parameter int DEPTH = cqse_pkg::DEPTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cqse_pkg::cqse_req_t req,
    output logic                    req_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_status,
    output logic signed [31:0]      m_result_value,
    output logic                    m_last
);
    import cqse_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_DISP  = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_CHECK = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [2:0]         op_reg, op_next;
    logic signed [31:0] key_reg, key_next;
    logic signed [31:0] repl_reg, repl_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [IDX_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]   occ_reg, occ_next;
    logic [IDX_W-1:0]   slot_reg, slot_next;
    logic [CNT_W-1:0]   n_reg, n_next;

    logic               m_valid_reg;
    logic [1:0]         m_status_reg;
    logic signed [31:0] m_value_reg;
    logic               m_last_reg;

    logic               out_free;
    logic               emit;
    logic [1:0]         e_status;
    logic [31:0]        e_value;
    logic               e_last;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [31:0]        ram_wdata;
    logic               ram_re;
    logic [31:0]        ram_rdata;
    logic               is_end;
    logic               hit;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] p);
        return (p == IDX_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    cqse_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign is_end   = (CNT_W'(n_reg + 1'b1) == occ_reg);
    assign hit      = (ram_rdata == key_reg);

    // Sequence one command at a time
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        repl_next  = repl_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        occ_next   = occ_reg;
        slot_next  = slot_reg;
        n_next     = n_reg;
        req_ready  = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = tail_reg;
        ram_wdata  = key_reg;
        ram_re     = 1'b0;
        emit       = 1'b0;
        e_status   = ST_OK;
        e_value    = '0;
        e_last     = 1'b1;

        case (state_reg)
            S_IDLE: begin
                req_ready = 1'b1;
                if (req.valid) begin
                    op_next    = req.cmd.op;
                    key_next   = req.cmd.data;
                    repl_next  = req.cmd.repl;
                    slot_next  = head_reg;
                    n_next     = '0;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                if (out_free) begin
                    if (op_reg == CMD_ENQ) begin
                        emit       = 1'b1;
                        state_next = S_IDLE;
                        if (occ_reg == CNT_W'(DEPTH)) begin
                            e_status = ST_FULL;
                        end else begin
                            ram_we    = 1'b1;
                            tail_next = idx_inc(tail_reg);
                            occ_next  = occ_reg + 1'b1;
                        end
                    end else if (occ_reg == '0) begin
                        emit       = 1'b1;
                        e_status   = ST_EMPTY;
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ: begin
                ram_re     = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (out_free) begin
                    case (op_reg)
                        CMD_DEQ: begin
                            emit       = 1'b1;
                            e_value    = ram_rdata;
                            head_next  = idx_inc(head_reg);
                            occ_next   = occ_reg - 1'b1;
                            state_next = S_IDLE;
                        end
                        CMD_TRAV: begin
                            emit    = 1'b1;
                            e_value = ram_rdata;
                            e_last  = is_end;
                            if (is_end) begin
                                state_next = S_IDLE;
                            end else begin
                                slot_next  = idx_inc(slot_reg);
                                n_next     = n_reg + 1'b1;
                                state_next = S_READ;
                            end
                        end
                        CMD_SRCH, CMD_EDIT: begin
                            if (hit) begin
                                emit       = 1'b1;
                                state_next = S_IDLE;
                                if (op_reg == CMD_EDIT) begin
                                    ram_we    = 1'b1;
                                    ram_waddr = slot_reg;
                                    ram_wdata = repl_reg;
                                end
                            end else if (is_end) begin
                                emit       = 1'b1;
                                e_status   = ST_MISS;
                                state_next = S_IDLE;
                            end else begin
                                slot_next  = idx_inc(slot_reg);
                                n_next     = n_reg + 1'b1;
                                state_next = S_READ;
                            end
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            occ_reg   <= occ_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Command payload, scan position and result register
    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        key_reg  <= key_next;
        repl_reg <= repl_next;
        slot_reg <= slot_next;
        n_reg    <= n_next;
        if (emit) begin
            m_status_reg <= e_status;
            m_value_reg  <= e_value;
            m_last_reg   <= e_last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_result_value = m_value_reg;
    assign m_last         = m_last_reg;

    a_occ_range: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= CNT_W'(DEPTH))
        else $error("occupancy exceeds depth");

    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_reg <= IDX_W'(DEPTH - 1)) && (tail_reg <= IDX_W'(DEPTH - 1)))
        else $error("ring pointer out of range");

    a_ptr_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (occ_reg == '0 || occ_reg == CNT_W'(DEPTH)) |-> (head_reg == tail_reg))
        else $error("head and tail disagree with occupancy");

    a_check_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CHECK) |-> ($past(state_reg) == S_READ || $past(state_reg) == S_CHECK))
        else $error("check without a preceding read");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(m_value_reg)))
        else $error("held result overwritten");

endmodule

`default_nettype wire

FILE: rtl/circular_queue_search_edit_core.sv
// Top level of the circular queue with search, edit and traverse commands.
//
//  channel | direction | ports                                   | handshake
//  s_      | in        | s_command, s_data_value, s_replacement  | s_valid / s_ready
//  m_      | out       | m_status, m_result_value, m_last        | m_valid / m_ready
//
// Enqueue and the empty or full cases finish in the dispatch state; dequeue also reads the RAM.
// Traverse, search and edit step through entries with the RAM read port,
// one read state and one check state per entry, up to DEPTH entries per command.
// A two-entry command queue in front lets inputs be taken while results stall.
// Reset (aresetn low, synchronous) empties the queue; RAM contents are not cleared.
// A stalled result holds the back end; the front keeps accepting until its queue fills.
`default_nettype none

module circular_queue_search_edit_core #(
    parameter int DEPTH = cqse_pkg::DEPTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_command,
    input  wire logic signed [31:0] s_data_value,
    input  wire logic signed [31:0] s_replacement,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_status,
    output logic signed [31:0]      m_result_value,
    output logic                    m_last
);
    import cqse_pkg::*;

    cqse_req_t req;
    logic      req_ready;

    cqse_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_data_value  (s_data_value),
        .s_replacement (s_replacement),
        .req           (req),
        .req_ready     (req_ready)
    );

    cqse_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .req            (req),
        .req_ready      (req_ready),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_result_value (m_result_value),
        .m_last         (m_last)
    );

endmodule

`default_nettype wire
